[sv/mandelbrot_escape_time_core_assert.svh]
// Assertion macros shared by the escape time core.
`ifndef MANDELBROT_ESCAPE_TIME_CORE_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define MBE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define MBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/mbe_pkg.sv]
// Types, constants and helpers for the escape time core.
package mbe_pkg;

  localparam int DATA_W      = 32;
  localparam int ITER_W      = 16;
  localparam int COORD_W     = 10;
  localparam int SHADE_W     = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int Q_FRAC      = 28;
  localparam int SAT_IN_W    = 48;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_REAL   = 3'd0,
    REG_MIN_IMAG   = 3'd1,
    REG_STEP_REAL  = 3'd2,
    REG_STEP_IMAG  = 3'd3,
    REG_ITER_LIMIT = 3'd4,
    REG_ESC_THRESH = 3'd5
  } cfg_reg_t;

  localparam logic [DATA_W-1:0] RST_MIN_REAL   = 32'hE000_0000;
  localparam logic [DATA_W-1:0] RST_MIN_IMAG   = 32'hF000_0000;
  localparam logic [DATA_W-1:0] RST_STEP_REAL  = 32'd786432;
  localparam logic [DATA_W-1:0] RST_STEP_IMAG  = 32'd524288;
  localparam logic [ITER_W-1:0] RST_ITER_LIMIT = 16'd256;
  localparam logic [DATA_W-1:0] RST_ESC_THRESH = 32'd1073741824;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] min_real;
    logic signed [DATA_W-1:0] min_imag;
    logic signed [DATA_W-1:0] step_real;
    logic signed [DATA_W-1:0] step_imag;
    logic [ITER_W-1:0]        iter_limit;
    logic [DATA_W-1:0]        escape_threshold;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0]       column;
    logic [COORD_W-1:0]       row;
    logic signed [DATA_W-1:0] c_real;
    logic signed [DATA_W-1:0] c_imag;
  } point_t;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [ITER_W-1:0]  iterations;
    logic               inside_res;
    logic [SHADE_W-1:0] shade;
  } result_t;

  // Clamps a wide signed value to the signed 32-bit range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] x);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &x[SAT_IN_W-1:DATA_W-1];
    hi_zeros = ~|x[SAT_IN_W-1:DATA_W-1];
    if (hi_ones || hi_zeros) begin
      return x[DATA_W-1:0];
    end else if (x[SAT_IN_W-1]) begin
      return Q_MIN;
    end else begin
      return Q_MAX;
    end
  endfunction

endpackage

[sv/mbe_fifo.sv]
// Small first-in first-out queue built from registers.
module mbe_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[sv/mbe_front.sv]
// Front end: takes pixels, drops those outside the image and maps the rest to points.
module mbe_front #(
  parameter int IMAGE_COLS = 1024,
  parameter int IMAGE_ROWS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mbe_pkg::cfg_t                 cfg,
  input  logic                          push,
  input  logic [mbe_pkg::COORD_W-1:0]   in_column,
  input  logic [mbe_pkg::COORD_W-1:0]   in_row,
  output logic                          full,
  output logic                          q_push,
  output mbe_pkg::point_t               q_data,
  input  logic                          q_full
);

  import mbe_pkg::*;

  localparam int LIM_W = 17;
  localparam logic [LIM_W-1:0] COL_LIM = LIM_W'(IMAGE_COLS);
  localparam logic [LIM_W-1:0] ROW_LIM = LIM_W'(IMAGE_ROWS);
  localparam int PROD_W = DATA_W + COORD_W + 1;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_ADD,
    F_PUSH
  } front_state_t;

  front_state_t              state_r;
  logic [COORD_W-1:0]        col_r;
  logic [COORD_W-1:0]        row_r;
  logic signed [PROD_W-1:0]  prod_re_r;
  logic signed [PROD_W-1:0]  prod_im_r;
  logic signed [DATA_W-1:0]  cr_r;
  logic signed [DATA_W-1:0]  ci_r;
  logic signed [COORD_W:0]   col_s;
  logic signed [COORD_W:0]   row_s;
  logic                      in_image;

  assign full     = (state_r != F_IDLE);
  assign in_image = (LIM_W'(in_column) < COL_LIM) && (LIM_W'(in_row) < ROW_LIM);
  assign col_s    = $signed({1'b0, col_r});
  assign row_s    = $signed({1'b0, row_r});

  assign q_push        = (state_r == F_PUSH);
  assign q_data.column = col_r;
  assign q_data.row    = row_r;
  assign q_data.c_real = cr_r;
  assign q_data.c_imag = ci_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (push && in_image) begin
            col_r   <= in_column;
            row_r   <= in_row;
            state_r <= F_MUL;
          end
        end
        F_MUL: begin
          prod_re_r <= PROD_W'(col_s) * PROD_W'(cfg.step_real);
          prod_im_r <= PROD_W'(row_s) * PROD_W'(cfg.step_imag);
          state_r   <= F_ADD;
        end
        F_ADD: begin
          cr_r    <= sat32(SAT_IN_W'(cfg.min_real) + SAT_IN_W'(prod_re_r));
          ci_r    <= sat32(SAT_IN_W'(cfg.min_imag) + SAT_IN_W'(prod_im_r));
          state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: begin
          state_r <= F_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/mbe_engine.sv]
// Back end: iterates z = z*z + c on one shared multiplier and forms the result.
module mbe_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  mbe_pkg::cfg_t     cfg,
  input  mbe_pkg::point_t   q_data,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              res_push,
  output mbe_pkg::result_t  res_data,
  input  logic              res_full
);

  import mbe_pkg::*;

  localparam int PROD_W = 2 * DATA_W;
  localparam int SQ_W   = PROD_W - Q_FRAC;
  localparam int MAG_W  = SQ_W;
  localparam int XP_W   = PROD_W - Q_FRAC + 1;
  localparam int SUM_W  = 40;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CHK,
    B_SQI,
    B_ESC,
    B_UPD,
    B_RES
  } engine_state_t;

  engine_state_t             state_r;
  point_t                    pt_r;
  logic signed [DATA_W-1:0]  zr_r;
  logic signed [DATA_W-1:0]  zi_r;
  logic [ITER_W-1:0]         k_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [SQ_W-1:0]    r2_r;
  logic signed [SQ_W-1:0]    i2_r;
  logic                      inside_r;
  logic signed [DATA_W-1:0]  mul_a;
  logic signed [DATA_W-1:0]  mul_b;
  logic signed [SQ_W-1:0]    i2;
  logic [MAG_W-1:0]          mag;
  logic                      escaped;
  logic signed [XP_W-1:0]    xp;
  logic signed [SUM_W-1:0]   nr_sum;
  logic signed [SUM_W-1:0]   ni_sum;

  always_comb begin
    case (state_r)
      B_CHK: begin
        mul_a = zr_r;
        mul_b = zr_r;
      end
      B_SQI: begin
        mul_a = zi_r;
        mul_b = zi_r;
      end
      default: begin
        mul_a = zr_r;
        mul_b = zi_r;
      end
    endcase
  end

  assign i2      = prod_r[PROD_W-1:Q_FRAC];
  assign mag     = MAG_W'(r2_r[SQ_W-2:0]) + MAG_W'(i2[SQ_W-2:0]);
  assign escaped = (mag >= MAG_W'(cfg.escape_threshold));
  assign xp      = prod_r[PROD_W-1:Q_FRAC-1];
  assign nr_sum  = SUM_W'(r2_r) - SUM_W'(i2_r) + SUM_W'(pt_r.c_real);
  assign ni_sum  = SUM_W'(xp) + SUM_W'(pt_r.c_imag);

  assign q_pop    = (state_r == B_IDLE) && !q_empty;
  assign res_push = (state_r == B_RES);

  assign res_data.column     = pt_r.column;
  assign res_data.row        = pt_r.row;
  assign res_data.iterations = k_r;
  assign res_data.inside_res = inside_r;
  assign res_data.shade      = inside_r ? '0 : k_r[SHADE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            pt_r    <= q_data;
            zr_r    <= '0;
            zi_r    <= '0;
            k_r     <= '0;
            state_r <= B_CHK;
          end
        end
        B_CHK: begin
          if (k_r == cfg.iter_limit) begin
            inside_r <= 1'b1;
            state_r  <= B_RES;
          end else begin
            prod_r  <= PROD_W'(mul_a) * PROD_W'(mul_b);
            state_r <= B_SQI;
          end
        end
        B_SQI: begin
          r2_r    <= prod_r[PROD_W-1:Q_FRAC];
          prod_r  <= PROD_W'(mul_a) * PROD_W'(mul_b);
          state_r <= B_ESC;
        end
        B_ESC: begin
          i2_r <= i2;
          if (escaped) begin
            inside_r <= 1'b0;
            state_r  <= B_RES;
          end else begin
            prod_r  <= PROD_W'(mul_a) * PROD_W'(mul_b);
            state_r <= B_UPD;
          end
        end
        B_UPD: begin
          zr_r    <= sat32(SAT_IN_W'(nr_sum));
          zi_r    <= sat32(SAT_IN_W'(ni_sum));
          k_r     <= k_r + 1'b1;
          state_r <= B_CHK;
        end
        B_RES: begin
          if (!res_full) begin
            state_r <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/mandelbrot_escape_time_core.sv]
// Top level of the escape time core: configuration registers, queues and the two halves.
//
// The input side is a queue: a pixel (in_column, in_row) transfers on a rising edge with
// push high and full low. Pixels outside the image are taken and dropped without a result.
// The result side is a queue too: while empty is low the oldest result sits on the out_
// ports and it transfers on a rising edge with pop high.
// Configuration is a write port (cfg_we, cfg_index, cfg_data), one register per write.
// The front end forms the point c for each pixel in the states F_MUL, F_ADD and F_PUSH and
// places it in a two-entry queue; it takes no new pixel until that point is handed off.
// The iteration engine owns one 32x32 multiplier and uses it three times per iteration,
// in the states B_CHK, B_SQI and B_ESC, and forms the next z in B_UPD; it takes the next
// point only after its result has been handed to the result queue. The sustained rate is
// set by the slower half, which is the engine unless the iteration limit is zero.
// A full result queue stalls the engine, which then stops draining the point queue, and
// full stays high while the front end holds a point that it cannot hand off.
// Synchronous reset empties both queues, idles both halves and loads the default view.
module mandelbrot_escape_time_core #(
  parameter int IMAGE_COLS = 1024,
  parameter int IMAGE_ROWS = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbe_pkg::DATA_W-1:0]      cfg_data,
  input  logic                            push,
  input  logic [mbe_pkg::COORD_W-1:0]     in_column,
  input  logic [mbe_pkg::COORD_W-1:0]     in_row,
  output logic                            full,
  input  logic                            pop,
  output logic                            empty,
  output logic [mbe_pkg::COORD_W-1:0]     out_column,
  output logic [mbe_pkg::COORD_W-1:0]     out_row,
  output logic [mbe_pkg::ITER_W-1:0]      out_iterations,
  output logic                            out_inside_res,
  output logic [mbe_pkg::SHADE_W-1:0]     out_shade
);

  import mbe_pkg::*;

  `include "mandelbrot_escape_time_core_assert.svh"

  cfg_t     cfg_r;
  point_t   q_wr_data;
  point_t   q_rd_data;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  result_t  res_wr_data;
  result_t  res_rd_data;
  logic     res_push;
  logic     res_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_real         <= RST_MIN_REAL;
      cfg_r.min_imag         <= RST_MIN_IMAG;
      cfg_r.step_real        <= RST_STEP_REAL;
      cfg_r.step_imag        <= RST_STEP_IMAG;
      cfg_r.iter_limit       <= RST_ITER_LIMIT;
      cfg_r.escape_threshold <= RST_ESC_THRESH;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_REAL:   cfg_r.min_real         <= cfg_data;
        REG_MIN_IMAG:   cfg_r.min_imag         <= cfg_data;
        REG_STEP_REAL:  cfg_r.step_real        <= cfg_data;
        REG_STEP_IMAG:  cfg_r.step_imag        <= cfg_data;
        REG_ITER_LIMIT: cfg_r.iter_limit       <= cfg_data[ITER_W-1:0];
        REG_ESC_THRESH: cfg_r.escape_threshold <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mbe_front #(
    .IMAGE_COLS (IMAGE_COLS),
    .IMAGE_ROWS (IMAGE_ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .push      (push),
    .in_column (in_column),
    .in_row    (in_row),
    .full      (full),
    .q_push    (q_push),
    .q_data    (q_wr_data),
    .q_full    (q_full)
  );

  mbe_fifo #(
    .WIDTH ($bits(point_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_point_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  mbe_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_data   (q_rd_data),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .res_push (res_push),
    .res_data (res_wr_data),
    .res_full (res_full)
  );

  mbe_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_wr_data),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_rd_data),
    .empty   (empty)
  );

  assign out_column     = res_rd_data.column;
  assign out_row        = res_rd_data.row;
  assign out_iterations = res_rd_data.iterations;
  assign out_inside_res = res_rd_data.inside_res;
  assign out_shade      = res_rd_data.shade;

  `MBE_ASSERT_IMPL(a_point_q_no_overrun, q_push, !q_full || full, "front lost its point")
  `MBE_ASSERT_NEXT(a_point_held, q_push && q_full, q_push, "front dropped a stalled point")
  `MBE_ASSERT_NEXT(a_result_held, res_push && res_full, res_push, "engine dropped a result")
  `MBE_ASSERT_IMPL(a_inside_dark, !empty && out_inside_res, out_shade == '0, "inside shaded")

endmodule
